// ===== design/kmp_pkg.sv =====
// Shared types and constants for the streaming KMP pattern matcher.
// No dependencies; used by the controller, datapath and top level.
package kmp_pkg;

  localparam int MAX_PATTERN = 32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEXT = 1'b1;

  // failure table read address source
  typedef enum logic [1:0] {
    FA_K,
    FA_J,
    FA_M
  } fail_sel_t;

  typedef struct packed {
    logic      load;
    logic      text_start;
    logic      build_init;
    logic      build_adv;
    logic      k_fb;
    logic      j_fb;
    logic      j_adv;
    logic      sel_build;
    fail_sel_t fail_sel;
    logic      commit;
  } dp_cmd_t;

  typedef struct packed {
    logic loading_done;
    logic len_zero;
    logic len_one;
    logic build_last;
    logic eq_build;
    logic k_zero;
    logic eq_text;
    logic j_zero;
    logic text_hit;
  } dp_status_t;

endpackage

// ===== design/kmp_req_if.sv =====
// Request channel: pattern load and text bytes, valid/ready handshake.
// Depends on nothing.
interface kmp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       pattern_last;

  modport source (output valid, req_type, data_byte, pattern_last, input ready);
  modport sink   (input valid, req_type, data_byte, pattern_last, output ready);
endinterface

// ===== design/kmp_res_if.sv =====
// Result channel: match flag, start position and running count.
// Depends on nothing.
interface kmp_res_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_position;
  logic [31:0] match_count;

  modport source (output valid, match_found, match_position, match_count, input ready);
  modport sink   (input valid, match_found, match_position, match_count, output ready);
endinterface

// ===== design/kmp_dp.sv =====
// Datapath: pattern and failure memories, match state, counters, result register.
// Depends on kmp_pkg; driven by kmp_ctrl through dp_cmd_t.
module kmp_dp #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN
) (
  input  logic                clk,
  input  logic                rst,
  input  kmp_pkg::dp_cmd_t    cmd,
  output kmp_pkg::dp_status_t status,
  input  logic [7:0]          data_byte,
  input  logic                pattern_last,
  output logic                match_found,
  output logic [31:0]         match_position,
  output logic [31:0]         match_count
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]    pat_mem  [MAX_PATTERN];
  logic [IW-1:0] fail_mem [MAX_PATTERN];

  logic [7:0]    pat_a;
  logic [7:0]    pat_b;
  logic [IW-1:0] fail_rd;

  logic [LW-1:0] len;
  logic          loading_done;
  logic [LW-1:0] matched;
  logic [31:0]   pos;
  logic [31:0]   found;
  logic [7:0]    c_r;
  logic [LW-1:0] j;
  logic [LW-1:0] k;
  logic [LW-1:0] q;
  logic          hit_r;
  logic          upd_prefix;
  logic          upd_pos;

  logic [LW-1:0] eff_len;
  logic [LW-1:0] j_init;
  logic [LW-1:0] jn;
  logic [LW-1:0] kn;
  logic [LW-1:0] fail_addr;
  logic [LW-1:0] pat_a_addr;
  logic [IW-1:0] fail_wr_addr;
  logic [31:0]   count_next;
  logic          eq_build;
  logic          eq_text;

  assign eff_len    = loading_done ? '0 : len;
  assign j_init     = (matched >= len) ? '0 : matched;
  assign eq_build   = (pat_a == pat_b);
  assign eq_text    = (c_r == pat_a);
  assign jn         = j + LW'(eq_text);
  assign kn         = k + LW'(eq_build);
  assign pat_a_addr = cmd.sel_build ? q : j;
  assign count_next = found + 32'(hit_r);
  assign fail_wr_addr = cmd.build_init ? '0 : q[IW-1:0];

  always_comb begin
    unique case (cmd.fail_sel)
      kmp_pkg::FA_K: fail_addr = k - LW'(1);
      kmp_pkg::FA_J: fail_addr = j - LW'(1);
      kmp_pkg::FA_M: fail_addr = len - LW'(1);
      default:       fail_addr = '0;
    endcase
  end

  always_comb begin
    status.loading_done = loading_done;
    status.len_zero     = (len == '0);
    status.len_one      = (len == LW'(1));
    status.build_last   = ((q + LW'(1)) == len);
    status.eq_build     = eq_build;
    status.k_zero       = (k == '0);
    status.eq_text      = eq_text;
    status.j_zero       = (j == '0);
    status.text_hit     = (jn == len);
  end

  // memories: one write port each, registered reads
  always_ff @(posedge clk) begin
    if (cmd.load && (eff_len < LW'(MAX_PATTERN))) begin
      pat_mem[eff_len[IW-1:0]] <= data_byte;
    end
    pat_a <= pat_mem[pat_a_addr[IW-1:0]];
    pat_b <= pat_mem[k[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init || cmd.build_adv) begin
      fail_mem[fail_wr_addr] <= cmd.build_init ? '0 : kn[IW-1:0];
    end
    fail_rd <= fail_mem[fail_addr[IW-1:0]];
  end

  // working registers of one build or one text step, and the result register
  always_ff @(posedge clk) begin
    if (cmd.text_start) begin
      c_r        <= data_byte;
      hit_r      <= 1'b0;
      upd_prefix <= loading_done && (len != '0);
      upd_pos    <= loading_done;
      j          <= j_init;
    end
    if (cmd.j_adv) begin
      j     <= jn;
      hit_r <= (jn == len);
    end
    if (cmd.j_fb) begin
      j <= LW'(fail_rd);
    end
    if (cmd.build_init) begin
      q <= LW'(1);
      k <= '0;
    end
    if (cmd.build_adv) begin
      q <= q + LW'(1);
      k <= kn;
    end
    if (cmd.k_fb) begin
      k <= LW'(fail_rd);
    end
    if (cmd.commit) begin
      match_found    <= hit_r;
      match_position <= hit_r ? (pos - (32'(len) - 32'd1)) : '0;
      match_count    <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      loading_done <= 1'b1;
      matched      <= '0;
      pos          <= '0;
      found        <= '0;
    end else begin
      if (cmd.load) begin
        // bytes beyond the store are dropped, length saturates
        len          <= (eff_len < LW'(MAX_PATTERN)) ? eff_len + LW'(1) : eff_len;
        loading_done <= pattern_last;
        if (pattern_last) begin
          matched <= '0;
          pos     <= '0;
          found   <= '0;
        end
      end
      if (cmd.commit) begin
        found <= count_next;
        if (upd_prefix) begin
          matched <= j;
        end
        if (upd_pos) begin
          pos <= pos + 32'd1;
        end
      end
    end
  end

endmodule

// ===== design/kmp_ctrl.sv =====
// Controller: sequences loads, the failure table build and each text step.
// Depends on kmp_pkg; commands kmp_dp through dp_cmd_t.
module kmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output kmp_pkg::dp_cmd_t    cmd,
  input  kmp_pkg::dp_status_t status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_B_INIT = 4'd1;
  localparam logic [3:0] S_B_RD   = 4'd2;
  localparam logic [3:0] S_B_CMP  = 4'd3;
  localparam logic [3:0] S_B_FB   = 4'd4;
  localparam logic [3:0] S_T_RD   = 4'd5;
  localparam logic [3:0] S_T_CMP  = 4'd6;
  localparam logic [3:0] S_T_FB   = 4'd7;
  localparam logic [3:0] S_T_HIT  = 4'd8;
  localparam logic [3:0] S_T_WB   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.fail_sel = kmp_pkg::FA_K;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == kmp_pkg::REQ_TEXT) begin
            cmd.text_start = 1'b1;
            state_next = (!status.loading_done || status.len_zero) ? S_T_WB : S_T_RD;
          end else begin
            cmd.load = 1'b1;
            if (in_last) begin
              state_next = S_B_INIT;
            end
          end
        end
      end
      S_B_INIT: begin
        cmd.build_init = 1'b1;
        state_next = status.len_one ? S_IDLE : S_B_RD;
      end
      S_B_RD: begin
        cmd.sel_build = 1'b1;
        state_next = S_B_CMP;
      end
      S_B_CMP: begin
        cmd.sel_build = 1'b1;
        if (!status.k_zero && !status.eq_build) begin
          cmd.fail_sel = kmp_pkg::FA_K;
          state_next = S_B_FB;
        end else begin
          cmd.build_adv = 1'b1;
          state_next = status.build_last ? S_IDLE : S_B_RD;
        end
      end
      S_B_FB: begin
        cmd.k_fb = 1'b1;
        state_next = S_B_RD;
      end
      S_T_RD: begin
        state_next = S_T_CMP;
      end
      S_T_CMP: begin
        if (!status.j_zero && !status.eq_text) begin
          cmd.fail_sel = kmp_pkg::FA_J;
          state_next = S_T_FB;
        end else begin
          cmd.j_adv = 1'b1;
          if (status.text_hit) begin
            // fetch the table entry for the full match to restart from
            cmd.fail_sel = kmp_pkg::FA_M;
            state_next = S_T_HIT;
          end else begin
            state_next = S_T_WB;
          end
        end
      end
      S_T_FB: begin
        cmd.j_fb = 1'b1;
        state_next = S_T_RD;
      end
      S_T_HIT: begin
        cmd.j_fb = 1'b1;
        state_next = S_T_WB;
      end
      S_T_WB: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/kmp_stream_pattern_matcher_core.sv =====
// Load bytes go back to back; the last adds the table build (init, a read and compare per
// further position, a fallback per mismatch). Text byte: read, compare, fallback per mismatch,
// restart on a full match (registered memory reads), then write-back, which a result held by
// the sink stalls; no request is taken meanwhile. With a load open or no pattern, text goes
// straight to write-back. Synchronous reset clears control state and counters; the pattern
// and failure memories are not cleared and hold nothing valid until a pattern is loaded.
module kmp_stream_pattern_matcher_core #(
  parameter int MAX_PATTERN = kmp_pkg::MAX_PATTERN
) (
  input logic      clk,
  input logic      rst,
  kmp_req_if.sink  req,
  kmp_res_if.source res
);

  kmp_pkg::dp_cmd_t    cmd;
  kmp_pkg::dp_status_t status;

  kmp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_req_type (req.req_type),
    .in_last     (req.pattern_last),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .cmd         (cmd),
    .status      (status)
  );

  kmp_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .data_byte      (req.data_byte),
    .pattern_last   (req.pattern_last),
    .match_found    (res.match_found),
    .match_position (res.match_position),
    .match_count    (res.match_count)
  );

endmodule

// ===== design/kmp_checker.sv =====
// Port-level checks for the KMP matcher, bound to the top level.
// Depends on kmp_req_if and kmp_res_if signals through the bind below.
module kmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        req_type,
  input logic        req_last,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_found,
  input logic [31:0] res_position
);

  // a result waiting for the sink stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // a text byte or a final pattern byte keeps the block busy the next cycle
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_type || req_last) |=> !req_ready)
    else $error("request taken while work in progress");

  // a result without a match carries start position zero
  a_no_match_pos: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_position == 32'd0)
    else $error("position set without a match");

endmodule

bind kmp_stream_pattern_matcher_core kmp_checker u_kmp_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_type     (req.req_type),
  .req_last     (req.pattern_last),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_found    (res.match_found),
  .res_position (res.match_position)
);

// ===== dv/kmp_match_checker.sv =====
// Scoreboard for the streaming KMP matcher: watches both channels, keeps its own
// copy of pattern, prefix table and counters, and compares every result transfer.
// Depends on kmp_pkg and the kmp_req_if / kmp_res_if interfaces.
module kmp_match_checker (
  input  logic clk,
  input  logic rst,
  kmp_req_if   req,
  kmp_res_if   res,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic [31:0] count;
  } match_result_t;

  logic [7:0]    pat_bytes [kmp_pkg::MAX_PATTERN];
  logic [5:0]    lps [kmp_pkg::MAX_PATTERN];
  logic [5:0]    pat_len;
  logic          load_closed;
  logic [5:0]    prefix_len;
  logic [31:0]   text_idx;
  logic [31:0]   hit_count;
  match_result_t match_q[$];
  int            fail_count = 0;
  int            queued = 0;

  assign errors  = fail_count;
  assign pending = queued;

  function automatic void build_lps();
    int n;
    int k;
    n = pat_len;
    k = 0;
    if (n == 0) return;
    lps[0] = '0;
    for (int q = 1; q < n; q++) begin
      while (k > 0 && pat_bytes[q] != pat_bytes[k]) k = lps[k-1];
      if (pat_bytes[q] == pat_bytes[k]) k++;
      lps[q] = 6'(k);
    end
  endfunction

  function automatic void take_load(logic [7:0] c, logic last);
    // first byte after a finished load starts a new pattern
    if (load_closed) begin
      pat_len     = '0;
      load_closed = 1'b0;
    end
    // drop bytes past the store, length saturates
    if (pat_len < kmp_pkg::MAX_PATTERN) begin
      pat_bytes[pat_len] = c;
      pat_len++;
    end
    if (last) begin
      build_lps();
      prefix_len  = '0;
      text_idx    = '0;
      hit_count   = '0;
      load_closed = 1'b1;
    end
  endfunction

  function automatic match_result_t scan_byte(logic [7:0] c);
    match_result_t r;
    int m;
    int j;
    r = '0;
    // text while a load is open: report the count, touch nothing
    if (!load_closed) begin
      r.count = hit_count;
      return r;
    end
    m = pat_len;
    if (m > 0) begin
      j = prefix_len;
      if (j >= m) j = 0;
      while (j > 0 && c != pat_bytes[j]) j = lps[j-1];
      if (c == pat_bytes[j]) j++;
      if (j == m) begin
        r.found = 1'b1;
        r.start = text_idx - 32'(m - 1);
        hit_count++;
        j = lps[m-1];
      end
      prefix_len = 6'(j);
    end
    text_idx++;
    r.count = hit_count;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    match_result_t want;
    if (rst) begin
      pat_len     = '0;
      load_closed = 1'b1;
      prefix_len  = '0;
      text_idx    = '0;
      hit_count   = '0;
      match_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        if (req.req_type == kmp_pkg::REQ_LOAD) take_load(req.data_byte, req.pattern_last);
        else match_q.push_back(scan_byte(req.data_byte));
      end
      if (res.valid && res.ready) begin
        if (match_q.size() == 0) begin
          $error("result transfer with no match result pending");
          fail_count++;
        end else begin
          want = match_q.pop_front();
          if (res.match_found !== want.found) begin
            $error("match_found: expected %0d, got %0d", want.found, res.match_found);
            fail_count++;
          end
          if (res.match_position !== want.start) begin
            $error("match_position: expected %0d, got %0d", want.start, res.match_position);
            fail_count++;
          end
          if (res.match_count !== want.count) begin
            $error("match_count: expected %0d, got %0d", want.count, res.match_count);
            fail_count++;
          end
        end
      end
    end
    queued = match_q.size();
  end

endmodule

// ===== dv/tb_kmp_stream_pattern_matcher_core.sv =====
// Top of the KMP matcher bench: clock, reset, request stimulus and result back-pressure.
// Depends on kmp_pkg, both channel interfaces, the core and kmp_match_checker.
module tb_kmp_stream_pattern_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 450;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  int   items_sent = 0;
  bit   quiet = 1'b0;

  kmp_req_if req_ch ();
  kmp_res_if res_ch ();

  kmp_stream_pattern_matcher_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  kmp_match_checker u_check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .errors  (fail_count),
    .pending (pending_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure.
  initial begin : sink_stall
    int stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = (quiet || $urandom_range(0, 99) >= 25) ? 0 : pick_gap();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_req(input logic kind, input logic [7:0] value, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.data_byte    <= value;
    req_ch.pattern_last <= last;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(input logic [7:0] value);
    send_req(kmp_pkg::REQ_TEXT, value, 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [7:0] pick_char(logic [7:0] base, int alpha);
    return base + 8'($urandom_range(0, alpha - 1));
  endfunction

  // One pattern load followed by a stretch of text, mostly drawn from the same alphabet.
  task automatic run_session();
    logic [7:0] pat [40];
    logic [7:0] base;
    int plen;
    int alpha;
    int tlen;
    int r;
    int kept;
    r = $urandom_range(0, 99);
    if (r < 78) plen = $urandom_range(1, 6);
    else if (r < 90) plen = $urandom_range(7, 16);
    else if (r < 95) plen = kmp_pkg::MAX_PATTERN;
    else plen = $urandom_range(kmp_pkg::MAX_PATTERN + 1, kmp_pkg::MAX_PATTERN + 4);
    alpha = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 3);
    base  = 8'($urandom_range(0, 255));
    quiet = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < plen; i++) pat[i] = pick_char(base, alpha);
    for (int i = 0; i < plen; i++) begin
      send_req(kmp_pkg::REQ_LOAD, pat[i], i == plen - 1);
      // text sneaking into an open load
      if (i < plen - 1 && $urandom_range(0, 99) < 8) send_text(pick_char(base, alpha));
    end
    kept = (plen > kmp_pkg::MAX_PATTERN) ? kmp_pkg::MAX_PATTERN : plen;
    tlen = $urandom_range(8, 40);
    for (int n = 0; n < tlen; n++) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        for (int i = 0; i < kept; i++) send_text(pat[i]);
      end else if (r < 30) begin
        send_text(8'($urandom_range(0, 255)));
      end else begin
        send_text(pick_char(base, alpha));
      end
    end
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = kmp_pkg::REQ_LOAD;
    req_ch.data_byte    = 8'h00;
    req_ch.pattern_last = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty pattern right after reset: no match, position still advances
    send_req(kmp_pkg::REQ_TEXT, 8'h00, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'hFF, 1'b1);

    // two-byte repeat pattern, overlapping matches
    send_req(kmp_pkg::REQ_LOAD, 8'hFF, 1'b0);
    send_req(kmp_pkg::REQ_LOAD, 8'hFF, 1'b1);
    send_req(kmp_pkg::REQ_TEXT, 8'hFF, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'hFF, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'hFF, 1'b1);
    send_req(kmp_pkg::REQ_TEXT, 8'h00, 1'b0);

    // text during an unfinished load keeps the old count
    send_req(kmp_pkg::REQ_LOAD, 8'h41, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'h41, 1'b0);
    send_req(kmp_pkg::REQ_LOAD, 8'h42, 1'b1);
    send_req(kmp_pkg::REQ_TEXT, 8'h41, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'h42, 1'b0);

    // single-byte pattern at the low extreme
    send_req(kmp_pkg::REQ_LOAD, 8'h00, 1'b1);
    send_req(kmp_pkg::REQ_TEXT, 8'h00, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'h01, 1'b0);
    send_req(kmp_pkg::REQ_TEXT, 8'h00, 1'b1);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) run_session();

    req_ch.valid <= 1'b0;
    quiet = 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
